// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define SLAQ_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition that must never hold outside reset
`define SLAQ_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define SLAQ_ASSERT(name, clk, rst_n, prop)
`define SLAQ_NEVER(name, clk, rst_n, cond)

`endif

`endif

// ===== sv/slaq_pkg.sv =====
// types and constants of the serial line assembler queue
`default_nettype none

package slaq_pkg;

	localparam logic [1:0] REQ_BYTE  = 2'd0;
	localparam logic [1:0] REQ_TAKE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [7:0] CHAR_LOW  = 8'h20;
	localparam logic [7:0] CHAR_HIGH = 8'h7E;
	localparam logic [7:0] NEWLINE   = 8'h0A;

	// command kinds passed from front to back
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_NL    = 2'd1;
	localparam logic [1:0] KIND_TAKE  = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] byte_value;
	} in_t;

	typedef struct packed {
		logic [6:0] line_char;
		logic       line_valid;
		logic       last_char;
		logic       overflow_seen;
		logic [1:0] lines_pending;
	} out_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] ch;
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/slaq_front.sv =====
// front end: classifies incoming words and queues them as commands
`default_nettype none

`include "assert_macros.svh"

module slaq_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire slaq_pkg::in_t  req,
	output logic                cmd_valid,
	output slaq_pkg::cmd_t      cmd,
	input  wire logic           cmd_pop
);
	import slaq_pkg::*;

	cmd_t       cmd_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       keep;
	logic       push;

	// drop words that never change state
	always_comb begin
		cls.kind = KIND_CHAR;
		cls.ch   = req.byte_value[6:0];
		keep     = 1'b0;
		case (req.req_type)
			REQ_BYTE: begin
				if (req.byte_value == NEWLINE) begin
					cls.kind = KIND_NL;
					keep     = 1'b1;
				end else if (req.byte_value inside {[CHAR_LOW:CHAR_HIGH]}) begin
					cls.kind = KIND_CHAR;
					keep     = 1'b1;
				end
			end
			REQ_TAKE: begin
				cls.kind = KIND_TAKE;
				keep     = 1'b1;
			end
			REQ_CLEAR: begin
				cls.kind = KIND_CLEAR;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign req_ready = (cnt_q != 2'd2);
	assign push      = req_valid && req_ready && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cmd_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (cmd_pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`SLAQ_ASSERT(a_pop_nonempty, clk, arst_n, cmd_pop |-> cnt_q != 2'd0)
	`SLAQ_NEVER(a_cnt_bound, clk, arst_n, cnt_q == 2'd3)
	`SLAQ_ASSERT(a_push_counts, clk, arst_n, (push && !cmd_pop) |=> cnt_q == $past(cnt_q) + 2'd1)

endmodule

`default_nettype wire

// ===== sv/slaq_back.sv =====
// back end: line assembly, slot store, take and clear handling, result register
`default_nettype none

`include "assert_macros.svh"

module slaq_back #(
	parameter int LINE_SIZE   = 16,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	input  wire slaq_pkg::cmd_t  cmd,
	output logic                 cmd_pop,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output slaq_pkg::out_t       rsp
);
	import slaq_pkg::*;

	localparam int LW        = $clog2(LINE_SIZE);
	localparam int LINE_MAX  = LINE_SIZE - 1;
	// one spare slot always holds the line under assembly
	localparam int NSLOT     = QUEUE_DEPTH + 1;
	localparam int SW        = $clog2(NSLOT);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NSLOT * (2 ** LW);
	localparam int AW        = SW + LW;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_TAKE = 1'b1;

	logic [6:0]    mem [MEM_DEPTH];
	logic [LW-1:0] slot_len_q [NSLOT];

	logic          state_q;
	logic [LW-1:0] len_q;
	logic          discard_q;
	logic          ovf_q;
	logic [SW-1:0] wr_q;
	logic [SW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] take_slot_q;
	logic [LW-1:0] take_idx_q;
	logic [LW-1:0] take_len_q;

	logic          valid_s1;
	logic          is_char_s1;
	logic          last_s1;
	logic          ovf_s1;
	logic [1:0]    pend_s1;
	logic [6:0]    rdata_s1;
	logic          rsp_valid_q;
	out_t          rsp_q;

	logic          adv_out;
	logic          adv_s1;
	logic          issue;
	logic          issue_char;
	logic          issue_last;
	logic          mem_we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic          take_end;

	function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
		return (s == SW'(NSLOT - 1)) ? '0 : s + 1'b1;
	endfunction

	assign adv_out  = !rsp_valid_q || rsp_ready;
	assign adv_s1   = !valid_s1 || adv_out;
	assign waddr    = {wr_q, len_q};
	assign raddr    = {take_slot_q, take_idx_q};
	assign take_end = ((LW + 1)'(take_idx_q) + 1'b1) == (LW + 1)'(take_len_q);

	always_comb begin
		cmd_pop    = 1'b0;
		issue      = 1'b0;
		issue_char = 1'b0;
		issue_last = 1'b1;
		mem_we     = 1'b0;
		if (state_q == ST_TAKE) begin
			issue      = adv_s1;
			issue_char = 1'b1;
			issue_last = take_end;
		end else if (cmd_valid) begin
			case (cmd.kind)
				KIND_CHAR: begin
					cmd_pop = 1'b1;
					mem_we  = !discard_q && (len_q < LW'(LINE_MAX));
				end
				KIND_NL: begin
					cmd_pop = 1'b1;
				end
				KIND_TAKE: begin
					if (count_q == '0) begin
						cmd_pop = adv_s1;
						issue   = adv_s1;
					end else begin
						cmd_pop = 1'b1;
					end
				end
				KIND_CLEAR: begin
					cmd_pop = adv_s1;
					issue   = adv_s1;
				end
				default: begin
					cmd_pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= cmd.ch;
		end
		if (adv_s1) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.kind == KIND_NL && !discard_q && len_q != '0
				&& count_q < CW'(QUEUE_DEPTH)) begin
			slot_len_q[wr_q] <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			discard_q   <= 1'b0;
			ovf_q       <= 1'b0;
			wr_q        <= '0;
			rd_q        <= '0;
			count_q     <= '0;
			take_slot_q <= '0;
			take_idx_q  <= '0;
			take_len_q  <= '0;
		end else if (state_q == ST_TAKE) begin
			if (adv_s1) begin
				take_idx_q <= take_idx_q + 1'b1;
				if (take_end) begin
					state_q <= ST_IDLE;
				end
			end
		end else if (cmd_pop) begin
			case (cmd.kind)
				KIND_CHAR: begin
					if (!discard_q) begin
						if (len_q < LW'(LINE_MAX)) begin
							len_q <= len_q + 1'b1;
						end else begin
							discard_q <= 1'b1;
							len_q     <= '0;
						end
					end
				end
				KIND_NL: begin
					if (discard_q) begin
						discard_q <= 1'b0;
						ovf_q     <= 1'b1;
						len_q     <= '0;
					end else if (len_q != '0) begin
						if (count_q < CW'(QUEUE_DEPTH)) begin
							wr_q    <= slot_next(wr_q);
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						len_q <= '0;
					end
				end
				KIND_TAKE: begin
					if (count_q != '0) begin
						state_q     <= ST_TAKE;
						take_slot_q <= rd_q;
						take_len_q  <= slot_len_q[rd_q];
						take_idx_q  <= '0;
						rd_q        <= slot_next(rd_q);
						count_q     <= count_q - 1'b1;
					end
				end
				KIND_CLEAR: begin
					ovf_q <= 1'b0;
				end
				default: begin
					ovf_q <= ovf_q;
				end
			endcase
		end
	end

	// result metadata travels alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			is_char_s1 <= issue_char;
			last_s1    <= issue_last;
			ovf_s1     <= ovf_q;
			pend_s1    <= 2'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_out) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			rsp_q.line_char     <= is_char_s1 ? rdata_s1 : 7'd0;
			rsp_q.line_valid    <= is_char_s1;
			rsp_q.last_char     <= last_s1;
			rsp_q.overflow_seen <= ovf_s1;
			rsp_q.lines_pending <= pend_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SLAQ_NEVER(a_count_bound, clk, arst_n, count_q > CW'(QUEUE_DEPTH))
	`SLAQ_ASSERT(a_discard_empty, clk, arst_n, discard_q |-> len_q == '0)
	`SLAQ_ASSERT(a_take_len, clk, arst_n, state_q == ST_TAKE |-> take_len_q != '0)
	`SLAQ_NEVER(a_no_pop_in_take, clk, arst_n, state_q == ST_TAKE && cmd_pop)

endmodule

`default_nettype wire

// ===== sv/serial_line_assembler_queue.sv =====
// Serial line assembler queue.
// Request channel (req_valid/req_ready/req) takes one word per cycle until the
// front is full: a received byte, a take request or an overflow read-and-clear.
// Result channel (rsp_valid/rsp_ready/rsp) returns the words that take and clear
// requests make. A two-entry command queue parts the classifying front from the
// back end, so bytes keep flowing while results wait on a stalled receiver.
// A received byte gives no result. A clear gives one result; a take gives one
// result per character of the oldest line (one result if nothing is queued),
// one per cycle from the slot store while the receiver keeps up, after a start
// step that pops the take; a full line holds LINE_SIZE-1 characters.
// With nothing waiting ahead, the first result passes the command queue, the
// read stage and the result register; a take of a queued line adds its start step.
// The store read port and the result register set the one-result-per-cycle pace.
// A stalled receiver holds the result register, then the read stage, then takes
// and clears in the back end; the front accepts until its two entries are full.
// Reset empties the queue and clears the line under assembly, discard mode and
// the overflow flag at once; no sweep of the store is needed.
`default_nettype none

module serial_line_assembler_queue #(
	parameter int LINE_SIZE   = 16,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire slaq_pkg::in_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output slaq_pkg::out_t       rsp
);
	import slaq_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	slaq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	slaq_back #(
		.LINE_SIZE   (LINE_SIZE),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
